@@ rtl/bfd_pkg.sv @@
// shared types, constants and codes of the buffer-fill deframer
package bfd_pkg;

    localparam int MAX_CHUNKS         = 32;
    localparam int MAX_CHUNK_QUADLETS = 1024;

    localparam int QUADLET_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int QPC_W      = 11;
    localparam int CPB_W      = 6;
    localparam int CPI_W      = 5;
    localparam int KIND_W     = 2;
    localparam int OFFSET_W   = 17;
    localparam int LENGTH_W   = 17;
    localparam int COUNT_W    = 15;
    localparam int POS_W      = 15;
    localparam int BUFQ_W     = 16;
    localparam int BUFB_W     = 18;
    localparam int BPC_W      = 13;
    localparam int CONSUMED_W = 18;
    localparam int R0_W       = 12;

    // serial divider: dividend and divisor widths, one quotient bit a step
    localparam int DIV_N_W   = 19;
    localparam int DIV_D_W   = 18;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam logic [QPC_W-1:0] QPC_RESET = QPC_W'(256);
    localparam logic [CPB_W-1:0] CPB_RESET = CPB_W'(32);
    localparam logic [CPI_W-1:0] CPI_RESET = '0;
    localparam logic [QPC_W-1:0] QPC_MAX   = QPC_W'(MAX_CHUNK_QUADLETS);
    localparam logic [CPB_W-1:0] CPB_MIN   = CPB_W'(2);
    localparam logic [CPB_W-1:0] CPB_MAX   = CPB_W'(MAX_CHUNKS);

    localparam logic [CFG_IDX_W-1:0] REG_QPC = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CPB = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CPI = CFG_IDX_W'(2);

    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_EVENT = 1'b1;

    // header bytes plus timestamp bytes added to the payload length
    localparam logic [LENGTH_W-1:0] FRAME_OVERHEAD = LENGTH_W'(8);

    typedef enum logic [KIND_W-1:0] {
        KIND_DESC    = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_CHUNK   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        DIV_START_MOD = 2'd0,
        DIV_PHASE     = 2'd1,
        DIV_CHUNKS    = 2'd2,
        DIV_END_MOD   = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic     data_accept;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_latch;
        logic     emit_summary;
        logic     emit_chunk;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic div_done;
        logic chunks_zero;
        logic chunk_final;
    } dp_status_t;

endpackage

@@ rtl/bfd_div.sv @@
// restoring serial divider, one quotient bit per cycle
module bfd_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bfd_pkg::DIV_N_W-1:0]   dividend,
    input  logic [bfd_pkg::DIV_D_W-1:0]   divisor,
    output logic [bfd_pkg::DIV_N_W-1:0]   quot,
    output logic [bfd_pkg::DIV_D_W-1:0]   rem,
    output logic                          done
);
    import bfd_pkg::*;

    logic [DIV_N_W-1:0]   n_reg, n_next;
    logic [DIV_D_W-1:0]   r_reg, r_next;
    logic [DIV_D_W-1:0]   d_reg, d_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    always_comb
    begin
        trial = {r_reg, n_reg[DIV_N_W-1]};
        diff  = trial - {1'b0, d_reg};
        fits  = (trial >= {1'b0, d_reg});

        n_next    = n_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            n_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = DIV_CNT_W'(DIV_N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next   = {n_reg[DIV_N_W-2:0], fits};
            r_next   = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quot = n_reg;
    assign rem  = r_reg;
    assign done = done_reg;

endmodule

@@ rtl/bfd_datapath.sv @@
// deframer datapath: config, packet tracking, event arithmetic and result register
module bfd_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [bfd_pkg::QUADLET_W-1:0]    quadlet,
    input  bfd_pkg::dp_cmd_t                 cmd,
    output bfd_pkg::dp_status_t              status,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [bfd_pkg::KIND_W-1:0]       kind,
    output logic [bfd_pkg::OFFSET_W-1:0]     packet_offset,
    output logic [bfd_pkg::LENGTH_W-1:0]     packet_length,
    output logic [bfd_pkg::COUNT_W-1:0]      packet_count,
    output logic                             irq_mark,
    output logic                             last
);
    import bfd_pkg::*;

    logic [QPC_W-1:0]      cfg_qpc_reg, cfg_qpc_next;
    logic [CPB_W-1:0]      cfg_cpb_reg, cfg_cpb_next;
    logic [CPI_W-1:0]      cfg_cpi_reg, cfg_cpi_next;

    logic [POS_W-1:0]      wpos_reg, wpos_next;
    logic [POS_W-1:0]      pstart_reg, pstart_next;
    logic [POS_W-1:0]      qleft_reg, qleft_next;
    logic [LENGTH_W-1:0]   clen_reg, clen_next;
    logic [CONSUMED_W-1:0] consumed_reg, consumed_next;
    logic [OFFSET_W-1:0]   eso_reg, eso_next;
    logic [COUNT_W-1:0]    pcount_reg, pcount_next;
    logic [CPI_W-1:0]      phase_reg, phase_next;
    logic [OFFSET_W-1:0]   start_reg, start_next;
    logic [R0_W-1:0]       r0_reg, r0_next;
    logic [CPB_W-1:0]      chunks_reg, chunks_next;

    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [OFFSET_W-1:0]   out_offset_reg, out_offset_next;
    logic [LENGTH_W-1:0]   out_length_reg, out_length_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;
    logic                  out_irq_reg, out_irq_next;
    logic                  out_last_reg, out_last_next;

    logic [QPC_W-1:0]      qpc_eff;
    logic [CPB_W-1:0]      cpb_eff;
    logic [BUFQ_W-1:0]     buf_q;
    logic [BUFB_W-1:0]     buf_b;
    logic [BPC_W-1:0]      bpc;
    logic [POS_W-1:0]      pos_cur;
    logic [BUFQ_W-1:0]     pos_inc;
    logic [LENGTH_W-1:0]   hdr_len;
    logic [LENGTH_W-1:0]   hdr_round;
    logic [LENGTH_W-1:0]   cur_round;
    logic [POS_W-1:0]      qleft_dec;
    logic [CONSUMED_W:0]   consumed_sum;
    logic [CPI_W-1:0]      phase_inc;
    logic                  out_free;

    logic [DIV_N_W-1:0]    div_n;
    logic [DIV_D_W-1:0]    div_d;
    logic [DIV_N_W-1:0]    div_quot;
    logic [DIV_D_W-1:0]    div_rem;
    logic                  div_done;

    bfd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    // effective geometry: the config registers clamped to their legal ranges
    always_comb
    begin
        if (cfg_qpc_reg == '0)
            qpc_eff = QPC_W'(1);
        else if (cfg_qpc_reg > QPC_MAX)
            qpc_eff = QPC_MAX;
        else
            qpc_eff = cfg_qpc_reg;

        if (cfg_cpb_reg < CPB_MIN)
            cpb_eff = CPB_MIN;
        else if (cfg_cpb_reg > CPB_MAX)
            cpb_eff = CPB_MAX;
        else
            cpb_eff = cfg_cpb_reg;

        // clamped sizes keep the product within 16 bits
        buf_q = {{(BUFQ_W-QPC_W){1'b0}}, qpc_eff}
              * {{(BUFQ_W-CPB_W){1'b0}}, cpb_eff};
        buf_b = {buf_q, 2'b00};
        bpc   = {qpc_eff, 2'b00};
    end

    always_comb
    begin
        case (cmd.div_sel)
            DIV_START_MOD:
            begin
                div_n = {2'b00, eso_reg};
                div_d = buf_b;
            end
            DIV_PHASE:
            begin
                div_n = {2'b00, start_reg};
                div_d = {{(DIV_D_W-BPC_W){1'b0}}, bpc};
            end
            DIV_CHUNKS:
            begin
                div_n = {{(DIV_N_W-R0_W){1'b0}}, r0_reg} + {1'b0, consumed_reg};
                div_d = {{(DIV_D_W-BPC_W){1'b0}}, bpc};
            end
            DIV_END_MOD:
            begin
                div_n = {2'b00, start_reg} + {1'b0, consumed_reg};
                div_d = buf_b;
            end
            default:
            begin
                div_n = '0;
                div_d = buf_b;
            end
        endcase
    end

    always_comb
    begin
        out_free = !out_valid_reg || !result_stall;

        pos_cur   = ({1'b0, wpos_reg} >= buf_q) ? '0 : wpos_reg;
        pos_inc   = {1'b0, pos_cur} + BUFQ_W'(1);
        hdr_len   = {1'b0, quadlet[31:16]} + FRAME_OVERHEAD;
        hdr_round = hdr_len + LENGTH_W'(3);
        cur_round = clen_reg + LENGTH_W'(3);
        qleft_dec = qleft_reg - POS_W'(1);
        consumed_sum = {1'b0, consumed_reg} + {2'b00, cur_round[LENGTH_W-1:2], 2'b00};
        phase_inc = phase_reg + CPI_W'(1);

        cfg_qpc_next  = cfg_qpc_reg;
        cfg_cpb_next  = cfg_cpb_reg;
        cfg_cpi_next  = cfg_cpi_reg;
        wpos_next     = wpos_reg;
        pstart_next   = pstart_reg;
        qleft_next    = qleft_reg;
        clen_next     = clen_reg;
        consumed_next = consumed_reg;
        eso_next      = eso_reg;
        pcount_next   = pcount_reg;
        phase_next    = phase_reg;
        start_next    = start_reg;
        r0_next       = r0_reg;
        chunks_next   = chunks_reg;

        out_valid_next  = out_valid_reg && result_stall;
        out_kind_next   = out_kind_reg;
        out_offset_next = out_offset_reg;
        out_length_next = out_length_reg;
        out_count_next  = out_count_reg;
        out_irq_next    = out_irq_reg;
        out_last_next   = out_last_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_QPC: cfg_qpc_next = cfg_data[QPC_W-1:0];
                REG_CPB: cfg_cpb_next = cfg_data[CPB_W-1:0];
                REG_CPI: cfg_cpi_next = cfg_data[CPI_W-1:0];
                default: ;
            endcase
        end

        if (cmd.data_accept)
        begin
            wpos_next = (pos_inc >= buf_q) ? '0 : pos_inc[POS_W-1:0];
            if (qleft_reg == '0)
            begin
                // header quadlet opens a packet
                clen_next   = hdr_len;
                pstart_next = pos_cur;
                qleft_next  = hdr_round[LENGTH_W-1:2] - POS_W'(1);
            end
            else
            begin
                qleft_next = qleft_dec;
                if (qleft_dec == '0)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_DESC;
                    out_offset_next = {pstart_reg, 2'b00};
                    out_length_next = clen_reg;
                    out_count_next  = '0;
                    out_irq_next    = 1'b0;
                    out_last_next   = 1'b1;
                    consumed_next   = consumed_sum[CONSUMED_W] ? '1
                                    : consumed_sum[CONSUMED_W-1:0];
                    if (pcount_reg != '1)
                        pcount_next = pcount_reg + COUNT_W'(1);
                end
            end
        end

        if (cmd.div_latch)
        begin
            case (cmd.div_sel)
                DIV_START_MOD: start_next = div_rem[OFFSET_W-1:0];
                DIV_PHASE:     r0_next    = div_rem[R0_W-1:0];
                DIV_CHUNKS:    chunks_next = (div_quot > {{(DIV_N_W-CPB_W){1'b0}}, cpb_eff})
                                           ? cpb_eff : div_quot[CPB_W-1:0];
                DIV_END_MOD:   eso_next   = div_rem[OFFSET_W-1:0];
                default: ;
            endcase
        end

        if (cmd.emit_summary)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_SUMMARY;
            out_offset_next = '0;
            out_length_next = '0;
            out_count_next  = pcount_reg;
            out_irq_next    = 1'b0;
            out_last_next   = (chunks_reg == '0);
            consumed_next   = '0;
            pcount_next     = '0;
        end

        if (cmd.emit_chunk)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_CHUNK;
            out_offset_next = '0;
            out_length_next = '0;
            out_count_next  = '0;
            out_irq_next    = 1'b0;
            out_last_next   = (chunks_reg == CPB_W'(1));
            chunks_next     = chunks_reg - CPB_W'(1);
            // phase holds while marks are disabled
            if (cfg_cpi_reg != '0)
            begin
                if (phase_inc >= cfg_cpi_reg)
                begin
                    phase_next   = '0;
                    out_irq_next = 1'b1;
                end
                else
                    phase_next = phase_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_qpc_reg   <= QPC_RESET;
            cfg_cpb_reg   <= CPB_RESET;
            cfg_cpi_reg   <= CPI_RESET;
            wpos_reg      <= '0;
            pstart_reg    <= '0;
            qleft_reg     <= '0;
            clen_reg      <= '0;
            consumed_reg  <= '0;
            eso_reg       <= '0;
            pcount_reg    <= '0;
            phase_reg     <= '0;
            chunks_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_qpc_reg   <= cfg_qpc_next;
            cfg_cpb_reg   <= cfg_cpb_next;
            cfg_cpi_reg   <= cfg_cpi_next;
            wpos_reg      <= wpos_next;
            pstart_reg    <= pstart_next;
            qleft_reg     <= qleft_next;
            clen_reg      <= clen_next;
            consumed_reg  <= consumed_next;
            eso_reg       <= eso_next;
            pcount_reg    <= pcount_next;
            phase_reg     <= phase_next;
            chunks_reg    <= chunks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        r0_reg         <= r0_next;
        out_kind_reg   <= out_kind_next;
        out_offset_reg <= out_offset_next;
        out_length_reg <= out_length_next;
        out_count_reg  <= out_count_next;
        out_irq_reg    <= out_irq_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        status.out_free    = out_free;
        status.div_done    = div_done;
        status.chunks_zero = (chunks_reg == '0);
        status.chunk_final = (chunks_reg == CPB_W'(1));
    end

    assign result_valid  = out_valid_reg;
    assign kind          = out_kind_reg;
    assign packet_offset = out_offset_reg;
    assign packet_length = out_length_reg;
    assign packet_count  = out_count_reg;
    assign irq_mark      = out_irq_reg;
    assign last          = out_last_reg;

endmodule

@@ rtl/bfd_ctrl.sv @@
// deframer controller: item acceptance and event sequencing
module bfd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 action,
    output logic                 item_stall,
    input  bfd_pkg::dp_status_t  status,
    output bfd_pkg::dp_cmd_t     cmd
);
    import bfd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SUMMARY,
        ST_CHUNKS
    } state_t;

    state_t   state_reg, state_next;
    div_sel_t sel_reg, sel_next;

    always_comb
    begin
        state_next       = state_reg;
        sel_next         = sel_reg;
        item_stall       = 1'b1;
        cmd.data_accept  = 1'b0;
        cmd.div_start    = 1'b0;
        cmd.div_sel      = sel_reg;
        cmd.div_latch    = 1'b0;
        cmd.emit_summary = 1'b0;
        cmd.emit_chunk   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                item_stall = !status.out_free;
                if (item_valid && status.out_free)
                begin
                    if (action == ACT_EVENT)
                    begin
                        state_next = ST_DIV_GO;
                        sel_next   = DIV_START_MOD;
                    end
                    else
                        cmd.data_accept = 1'b1;
                end
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_latch = 1'b1;
                    state_next    = ST_DIV_GO;
                    case (sel_reg)
                        DIV_START_MOD: sel_next = DIV_PHASE;
                        DIV_PHASE:     sel_next = DIV_CHUNKS;
                        DIV_CHUNKS:    sel_next = DIV_END_MOD;
                        DIV_END_MOD:   state_next = ST_SUMMARY;
                        default:       state_next = ST_SUMMARY;
                    endcase
                end
            end
            ST_SUMMARY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_summary = 1'b1;
                    state_next = status.chunks_zero ? ST_IDLE : ST_CHUNKS;
                end
            end
            ST_CHUNKS:
            begin
                if (status.out_free)
                begin
                    cmd.emit_chunk = 1'b1;
                    if (status.chunk_final)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= DIV_START_MOD;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

@@ rtl/iso_buffer_fill_deframer.sv @@
// Buffer-fill receive deframer: one received quadlet per data item, header bits 31:16 give the
// payload length, each finished packet yields a descriptor with byte offset and length, and a
// completion event yields a summary with the packet count followed by one result per fully
// consumed buffer chunk. Data quadlets stream at one per cycle while the result side keeps up;
// a finished result waits in the output register. A completion event runs four divisions
// through a shared restoring divider that resolves one quotient bit per cycle (19 steps,
// with a set-up step before and a capture step after each), then emits the summary and one
// result per released chunk as the output register frees; no item is taken meanwhile.
module iso_buffer_fill_deframer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic                             action,
    input  logic [bfd_pkg::QUADLET_W-1:0]    quadlet,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [bfd_pkg::KIND_W-1:0]       kind,
    output logic [bfd_pkg::OFFSET_W-1:0]     packet_offset,
    output logic [bfd_pkg::LENGTH_W-1:0]     packet_length,
    output logic [bfd_pkg::COUNT_W-1:0]      packet_count,
    output logic                             irq_mark,
    output logic                             last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bfd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    bfd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .action     (action),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    bfd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .quadlet       (quadlet),
        .cmd           (cmd),
        .status        (status),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .kind          (kind),
        .packet_offset (packet_offset),
        .packet_length (packet_length),
        .packet_count  (packet_count),
        .irq_mark      (irq_mark),
        .last          (last)
    );

    // an accepted event blocks further items while it is worked out
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && action == ACT_EVENT) |=> item_stall)
        else $error("item taken right after a completion event");

    // a packet descriptor is always the sole result of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == KIND_DESC) |-> last)
        else $error("descriptor without last");

    // interrupt marks only ride on released chunks
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && irq_mark) |-> (kind == KIND_CHUNK))
        else $error("interrupt mark outside a chunk result");

    // a descriptor never carries a packet count
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == KIND_DESC) |-> (packet_count == '0))
        else $error("descriptor carries a packet count");

endmodule
